@@ src/sui_pkg.sv @@
package sui_pkg;

   localparam int CAPACITY    = 64;
   localparam int KEY_WIDTH   = 32;
   localparam int POS_WIDTH   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   typedef logic [KEY_WIDTH-1:0]   key_type;
   typedef logic [POS_WIDTH-1:0]   pos_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // per-cell flags seen by the neighbor and by the top level
   typedef struct packed {
      logic valid;   // cell holds a key
      logic at_end;  // this or an earlier cell is empty, equal or ranks after the new key
      logic ins;     // insert point: first such cell
      logic dup;     // insert point holds a key equal to the new key
   } cell_flags_type;

endpackage

@@ src/sui_cell.sv @@
module sui_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift_en,
   input  logic                    descending,
   input  sui_pkg::key_type        new_key,
   input  sui_pkg::key_type        left_key,
   input  sui_pkg::cell_flags_type left_flags,
   output sui_pkg::key_type        key,
   output sui_pkg::cell_flags_type flags
);

   sui_pkg::key_type key_ff;
   sui_pkg::key_type key_in;
   logic             valid_ff;
   logic             valid_in;
   logic             eq;
   logic             after;
   logic             hit;

   always_comb begin
      eq    = (key_ff == new_key);
      after = descending ? (key_ff < new_key) : (key_ff > new_key);
      hit   = ~valid_ff | eq | after;
      flags.valid  = valid_ff;
      flags.at_end = left_flags.at_end | hit;
      flags.ins    = hit & ~left_flags.at_end;
      flags.dup    = flags.ins & valid_ff & eq;
      key          = key_ff;
   end

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (shift_en) begin
         valid_in = valid_ff | left_flags.valid;
         if (flags.ins) begin
            key_in = new_key;
         end else if (flags.at_end) begin
            key_in = left_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

@@ src/sorted_unique_insert.sv @@
// Ordered set of up to sui_pkg::CAPACITY unique keys held in a row of cells.
// Every cell compares its key with the incoming item's key in the same cycle;
// on insert the cells at and after the insert point shift up by one in
// parallel. One item per cycle: the compare, neighbor flags and position
// encode happen in the accept cycle and the result is registered, so a new
// item is taken each cycle unless a held result is stalled. Duplicate keys
// and keys arriving while full leave the set unchanged.
module sorted_unique_insert (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_new_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_insert_status,
   output logic [6:0]  rsp_entry_count,
   output logic [5:0]  rsp_insert_position
);

   localparam int N = sui_pkg::CAPACITY;

   logic                    descending_ff;
   logic                    accept;
   logic                    shift_en;
   logic                    any_dup;
   logic                    full;
   sui_pkg::key_type        new_key;
   sui_pkg::key_type        cell_key   [N];
   sui_pkg::cell_flags_type cell_flags [N];
   sui_pkg::pos_type        position;
   sui_pkg::status_type     status;
   sui_pkg::count_type      count_ff;
   sui_pkg::count_type      count_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   sui_pkg::status_type     rsp_status_ff;
   sui_pkg::count_type      rsp_count_ff;
   sui_pkg::pos_type        rsp_pos_ff;

   assign new_key   = req_new_key[sui_pkg::KEY_WIDTH-1:0];
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // left neighbor of cell 0: always valid, never at/after the key
   localparam sui_pkg::cell_flags_type HEAD_FLAGS = '{valid: 1'b1, at_end: 1'b0,
                                                       ins: 1'b0, dup: 1'b0};

   for (genvar i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_head
         sui_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift_en   (shift_en),
            .descending (descending_ff),
            .new_key    (new_key),
            .left_key   (new_key),
            .left_flags (HEAD_FLAGS),
            .key        (cell_key[i]),
            .flags      (cell_flags[i])
         );
      end else begin : g_body
         sui_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift_en   (shift_en),
            .descending (descending_ff),
            .new_key    (new_key),
            .left_key   (cell_key[i-1]),
            .left_flags (cell_flags[i-1]),
            .key        (cell_key[i]),
            .flags      (cell_flags[i])
         );
      end
   end

   always_comb begin
      any_dup  = 1'b0;
      position = '0;
      for (int i = 0; i < N; i++) begin
         any_dup = any_dup | cell_flags[i].dup;
         if (cell_flags[i].ins) begin
            position = position | sui_pkg::pos_type'(i);
         end
      end
      full = (count_ff == sui_pkg::count_type'(N));
      if (any_dup) begin
         status = sui_pkg::ST_DUPLICATE;
      end else if (full) begin
         status = sui_pkg::ST_FULL;
      end else begin
         status = sui_pkg::ST_INSERTED;
      end
      shift_en = accept & (status == sui_pkg::ST_INSERTED);
      count_in = shift_en ? count_ff + sui_pkg::count_type'(1) : count_ff;
      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         descending_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            descending_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status;
         rsp_count_ff  <= count_in;
         rsp_pos_ff    <= (status == sui_pkg::ST_FULL) ? '0 : position;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_insert_status   = rsp_status_ff;
   assign rsp_entry_count     = 7'(rsp_count_ff);
   assign rsp_insert_position = 6'(rsp_pos_ff);

endmodule
